// ----- hw/rtl/usbvd_pkg.sv -----
package usbvd_pkg;

   localparam int KeptBytes = 6;

   localparam logic [7:0] REC_INTERFACE        = 8'h04;
   localparam logic [7:0] REC_CLASS_SPECIFIC   = 8'h24;
   localparam logic [7:0] VIDEO_CLASS          = 8'd14;
   localparam logic [7:0] VIDEO_CONTROL_SUB    = 8'd1;
   localparam logic [7:0] SUB_INPUT_TERMINAL   = 8'h02;
   localparam logic [7:0] SUB_PROCESSING_UNIT  = 8'h05;
   localparam logic [15:0] CAMERA_TERMINAL_TYPE = 16'h0201;
   localparam logic [7:0] CLASS_NONE           = 8'hFF;

   // One record, or a bare descriptor end, handed from the front to the back.
   typedef struct packed {
      logic                          evaluate;  // record finished or cut by the end
      logic                          last;      // descriptor ends with this request
      logic [KeptBytes-1:0][7:0]     rec;       // record bytes 1..6, type first
   } cmd_type;

   typedef struct packed {
      logic [7:0] control_interface;
      logic       control_found;
      logic [7:0] camera_terminal;
      logic       camera_found;
      logic [7:0] processing_unit;
      logic       unit_found;
      logic       complete;
   } result_type;

endpackage

// ----- hw/rtl/usbvd_front.sv -----
module usbvd_front
   import usbvd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [7:0]                pos_ff, pos_in;
   logic [7:0]                len_ff, len_in;
   logic                      stop_ff, stop_in;
   logic [KeptBytes-1:0][7:0] rec_ff, rec_in;
   logic                      accept;
   logic                      evaluate;
   logic [2:0]                idx;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign idx      = 3'(pos_ff - 8'd1);

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      stop_in  = stop_ff;
      rec_in   = rec_ff;
      evaluate = 1'b0;
      if (accept && !stop_ff) begin
         if (pos_ff == 8'd0) begin
            if (in_byte == 8'd0) begin
               stop_in = 1'b1;
            end else begin
               len_in = in_byte;
               rec_in = '0;
               // a one-byte record has no type byte
               pos_in = (in_byte == 8'd1) ? 8'd0 : 8'd1;
            end
         end else begin
            if (pos_ff <= 8'(KeptBytes)) begin
               rec_in[idx] = in_byte;
            end
            if ({1'b0, pos_ff} + 9'd1 >= {1'b0, len_ff}) begin
               evaluate = 1'b1;
               pos_in   = 8'd0;
            end else begin
               pos_in = pos_ff + 8'd1;
               if (in_last) begin
                  evaluate = 1'b1;
               end
            end
         end
      end
   end

   assign push              = accept && (evaluate || in_last);
   assign push_cmd.evaluate = evaluate;
   assign push_cmd.last     = in_last;
   assign push_cmd.rec      = rec_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         pos_ff  <= 8'd0;
         len_ff  <= 8'd0;
         stop_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         stop_ff <= stop_in;
      end
      rec_ff <= rec_in;
   end

endmodule

// ----- hw/rtl/usbvd_queue.sv -----
module usbvd_queue
   import usbvd_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   cmd_type               entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CntWidth'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/usbvd_back.sv -----
module usbvd_back
   import usbvd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic [7:0]  cls_ff, cls_in;
   logic [7:0]  sub_ff, sub_in;
   logic [8:0]  fctl_ff, fctl_in;
   logic [8:0]  fcam_ff, fcam_in;
   logic [8:0]  fpu_ff, fpu_in;
   logic        valid_ff, valid_in;
   result_type  result_ff, result_in;
   logic        out_free;
   logic        in_vc;
   logic [15:0] term;

   assign out_free = !valid_ff || out_ready;
   // hold a final request until the output register can take its result
   assign cmd_pop  = cmd_valid && (out_free || !cmd.last);
   assign in_vc    = (cls_ff == VIDEO_CLASS) && (sub_ff == VIDEO_CONTROL_SUB);
   assign term     = {cmd.rec[4], cmd.rec[3]};

   always_comb begin
      cls_in  = cls_ff;
      sub_in  = sub_ff;
      fctl_in = fctl_ff;
      fcam_in = fcam_ff;
      fpu_in  = fpu_ff;
      if (cmd_pop && cmd.evaluate) begin
         if (cmd.rec[0] == REC_INTERFACE) begin
            cls_in = cmd.rec[4];
            sub_in = cmd.rec[5];
            if (cmd.rec[4] == VIDEO_CLASS && cmd.rec[5] == VIDEO_CONTROL_SUB) begin
               fctl_in = {1'b1, cmd.rec[1]};
            end
         end else if (cmd.rec[0] == REC_CLASS_SPECIFIC && in_vc) begin
            if (cmd.rec[1] == SUB_INPUT_TERMINAL && term == CAMERA_TERMINAL_TYPE) begin
               fcam_in = {1'b1, cmd.rec[2]};
            end else if (cmd.rec[1] == SUB_PROCESSING_UNIT) begin
               fpu_in = {1'b1, cmd.rec[2]};
            end
         end
      end
   end

   always_comb begin
      result_in.control_interface = fctl_in[7:0];
      result_in.control_found     = fctl_in[8];
      result_in.camera_terminal   = fcam_in[7:0];
      result_in.camera_found      = fcam_in[8];
      result_in.processing_unit   = fpu_in[7:0];
      result_in.unit_found        = fpu_in[8];
      result_in.complete          = fctl_in[8] && fcam_in[8] && fpu_in[8];
      if (cmd_pop && cmd.last) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd_pop && cmd.last)) begin
         cls_ff  <= CLASS_NONE;
         sub_ff  <= CLASS_NONE;
         fctl_ff <= '0;
         fcam_ff <= '0;
         fpu_ff  <= '0;
      end else begin
         cls_ff  <= cls_in;
         sub_ff  <= sub_in;
         fctl_ff <= fctl_in;
         fcam_ff <= fcam_in;
         fpu_ff  <= fpu_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (cmd_pop && cmd.last) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ----- hw/rtl/usb_video_descriptor_scanner_core.sv -----
// Walks a USB configuration descriptor streamed in one byte per request and
// reports the video-control interface number, camera terminal ID and
// processing-unit ID, each with a found flag, plus a complete flag. Bytes
// are taken at one per clock while the queue has room; the front end tracks
// record boundaries and queues each finished record. One response follows
// the request marked tlast. The back end updates the match state at one
// record per cycle, unless a response waiting on rsp_tready holds the next
// final request at the head of the queue; records behind it wait there too,
// and req_tready drops once QUEUE_DEPTH queued entries, that final request
// included, are waiting. The next descriptor may start right after tlast.
module usb_video_descriptor_scanner_core
   import usbvd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // descriptor_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // control_interface, camera_terminal, processing_unit
   output logic [3:0]  rsp_tuser    // control_found, camera_found, unit_found, complete
);

   logic       push, full, pop, pop_valid;
   cmd_type    push_cmd, pop_cmd;
   result_type result;

   usbvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   usbvd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   usbvd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.processing_unit, result.camera_terminal,
                       result.control_interface};
   assign rsp_tuser = {result.complete, result.unit_found, result.camera_found,
                       result.control_found};

endmodule

// ----- hw/rtl/usbvd_checker.sv -----
module usbvd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3] == (rsp_tuser[0] && rsp_tuser[1] && rsp_tuser[2]))
      else $error("complete flag disagrees with found flags");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || rsp_tdata[7:0] == 8'd0) &&
                     (rsp_tuser[1] || rsp_tdata[15:8] == 8'd0) &&
                     (rsp_tuser[2] || rsp_tdata[23:16] == 8'd0))
      else $error("missing item reports nonzero ID");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind usb_video_descriptor_scanner_core usbvd_checker u_checker (.*);

// ----- tb/usb_video_descriptor_scanner_core_tb.sv -----
`timescale 1ns / 100ps

module usb_video_descriptor_scanner_core_tb;
   import usbvd_pkg::*;

   localparam int StallMax = 17;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // descriptor_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // control_interface, camera_terminal, processing_unit
   logic [3:0]  rsp_tuser;          // control_found, camera_found, unit_found, complete

   usb_video_descriptor_scanner_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Scanner state mirrored by the predictor.
   logic [7:0] rec_pos;
   logic [7:0] rec_len;
   logic [7:0] rec_field [KeptBytes];
   logic       walk_done;
   logic [7:0] if_num;
   logic [7:0] if_class;
   logic [7:0] if_subclass;
   logic [8:0] ctrl_seen;
   logic [8:0] camera_seen;
   logic [8:0] unit_seen;

   result_type scan_reports [$];
   logic [7:0] desc_bytes [$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   bit          req_no_gaps = 1'b0;
   bit          rsp_no_stall = 1'b0;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void start_new_descriptor();
      rec_pos = '0;
      rec_len = '0;
      foreach (rec_field[i]) rec_field[i] = '0;
      walk_done = 1'b0;
      if_num = '0;
      if_class = CLASS_NONE;
      if_subclass = CLASS_NONE;
      ctrl_seen = '0;
      camera_seen = '0;
      unit_seen = '0;
   endfunction

   function automatic bit in_video_control();
      return if_class == VIDEO_CLASS && if_subclass == VIDEO_CONTROL_SUB;
   endfunction

   function automatic void judge_record();
      logic [15:0] term;
      term = {rec_field[4], rec_field[3]};
      if (rec_field[0] == REC_INTERFACE) begin
         if_num = rec_field[1];
         if_class = rec_field[4];
         if_subclass = rec_field[5];
         if (in_video_control()) ctrl_seen = {1'b1, if_num};
      end else if (rec_field[0] == REC_CLASS_SPECIFIC && in_video_control()) begin
         if (rec_field[1] == SUB_INPUT_TERMINAL && term == CAMERA_TERMINAL_TYPE)
            camera_seen = {1'b1, rec_field[2]};
         else if (rec_field[1] == SUB_PROCESSING_UNIT)
            unit_seen = {1'b1, rec_field[2]};
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      result_type r;
      if (!walk_done) begin
         if (rec_pos == 0) begin
            if (b == 0) begin
               walk_done = 1'b1;
            end else begin
               rec_len = b;
               foreach (rec_field[i]) rec_field[i] = '0;
               // a one-byte record has no type: skip it
               rec_pos = (b == 1) ? 8'd0 : 8'd1;
            end
         end else begin
            if (rec_pos <= KeptBytes) rec_field[rec_pos - 1] = b;
            if (int'(rec_pos) + 1 >= int'(rec_len)) begin
               judge_record();
               rec_pos = '0;
            end else begin
               rec_pos = rec_pos + 1;
               if (last) judge_record();
            end
         end
      end
      if (last) begin
         r.control_interface = ctrl_seen[8] ? ctrl_seen[7:0] : 8'h00;
         r.control_found = ctrl_seen[8];
         r.camera_terminal = camera_seen[8] ? camera_seen[7:0] : 8'h00;
         r.camera_found = camera_seen[8];
         r.processing_unit = unit_seen[8] ? unit_seen[7:0] : 8'h00;
         r.unit_found = unit_seen[8];
         r.complete = ctrl_seen[8] & camera_seen[8] & unit_seen[8];
         scan_reports.push_back(r);
         start_new_descriptor();
      end
   endfunction

   function automatic void note_failure(string what, logic [7:0] want, logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
   endfunction

   function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) note_failure(what, want, got);
   endfunction

   // Check each accepted response against the oldest pending report.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scan_reports.size() == 0) begin
            note_failure("unexpected response", 8'h00, rsp_tdata[7:0]);
         end else begin
            want = scan_reports.pop_front();
            compare_field("control_interface", want.control_interface, rsp_tdata[7:0]);
            compare_field("camera_terminal", want.camera_terminal, rsp_tdata[15:8]);
            compare_field("processing_unit", want.processing_unit, rsp_tdata[23:16]);
            compare_field("control_found", 8'(want.control_found), 8'(rsp_tuser[0]));
            compare_field("camera_found", 8'(want.camera_found), 8'(rsp_tuser[1]));
            compare_field("unit_found", 8'(want.unit_found), 8'(rsp_tuser[2]));
            compare_field("complete", 8'(want.complete), 8'(rsp_tuser[3]));
         end
      end
   end

   // Response side: stall tready at random before each response, unless rsp_no_stall is set.
   int unsigned rsp_hold = 0;
   bit          rsp_armed = 1'b0;
   always @(posedge clock) begin
      int unsigned draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
         rsp_armed <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_armed <= 1'b0;
         rsp_tready <= rsp_no_stall || ($urandom_range(0, 1) == 1);
      end else if (rsp_tvalid) begin
         if (!rsp_armed) begin
            draw = rsp_no_stall ? 0 : $urandom_range(0, StallMax);
            rsp_armed <= 1'b1;
            rsp_hold <= draw;
            rsp_tready <= (draw == 0);
         end else begin
            rsp_hold <= (rsp_hold == 0) ? 0 : rsp_hold - 1;
            rsp_tready <= (rsp_hold <= 1);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int unsigned gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, StallMax);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, last);
   endtask

   task automatic send_desc_bytes();
      foreach (desc_bytes[i]) send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
   endtask

   // Stop requesting until every pending report has been returned.
   task automatic hold_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scan_reports.size() != 0) @(posedge clock);
   endtask

   function automatic void add_record(bit force_vc);
      int unsigned pick;
      int unsigned len;
      logic [15:0] term;
      logic [7:0]  head [$];
      pick = force_vc ? 5 : $urandom_range(0, 99);
      len = $urandom_range(2, 12);
      if (pick < 18) begin
         head = {REC_INTERFACE, rand_byte(), rand_byte(), rand_byte(),
                 VIDEO_CLASS, VIDEO_CONTROL_SUB};
         len = (pick < 3) ? $urandom_range(2, 6) : $urandom_range(7, 12);
      end else if (pick < 28) begin
         head = {REC_INTERFACE, rand_byte(), rand_byte(), rand_byte(),
                 $urandom_range(0, 1) ? VIDEO_CLASS : rand_byte(),
                 $urandom_range(0, 1) ? VIDEO_CONTROL_SUB : rand_byte()};
         len = $urandom_range(7, 12);
      end else if (pick < 46) begin
         term = ($urandom_range(0, 9) != 0) ? CAMERA_TERMINAL_TYPE
                : CAMERA_TERMINAL_TYPE ^ (16'h0001 << $urandom_range(0, 15));
         head = {REC_CLASS_SPECIFIC, SUB_INPUT_TERMINAL, rand_byte(), term[7:0], term[15:8]};
         len = (pick < 30) ? $urandom_range(2, 5) : $urandom_range(6, 10);
      end else if (pick < 60) begin
         head = {REC_CLASS_SPECIFIC, SUB_PROCESSING_UNIT, rand_byte()};
         len = (pick < 48) ? $urandom_range(2, 3) : $urandom_range(4, 13);
      end else if (pick < 68) begin
         head = {REC_CLASS_SPECIFIC, rand_byte()};
         len = $urandom_range(3, 8);
      end else if (pick < 78) begin
         len = $urandom_range(2, 12);
      end else if (pick < 84) begin
         // long record: trailing bytes past the kept window
         head = {REC_CLASS_SPECIFIC, SUB_PROCESSING_UNIT, rand_byte()};
         len = $urandom_range(20, 40);
      end else if (pick < 90) begin
         len = 1;
      end else if (pick < 93) begin
         desc_bytes.push_back(8'h00);
         repeat ($urandom_range(0, 3)) desc_bytes.push_back(rand_byte());
         return;
      end else begin
         head = {rand_byte()};
         len = $urandom_range(2, 20);
      end
      desc_bytes.push_back(8'(len));
      for (int i = 1; i < len; i++)
         desc_bytes.push_back((i <= head.size()) ? head[i - 1] : rand_byte());
   endfunction

   task automatic send_random_descriptor();
      int unsigned ending;
      desc_bytes.delete();
      add_record($urandom_range(0, 4) != 0);
      repeat ($urandom_range(0, 4)) add_record(1'b0);
      ending = $urandom_range(0, 19);
      if (ending < 3)
         desc_bytes = desc_bytes[0:$urandom_range(0, desc_bytes.size() - 1)];
      else if (ending < 6)
         desc_bytes.push_back(rand_byte());
      send_desc_bytes();
   endtask

   task automatic test_directed_descriptors();
      // all three found; processing-unit record cut short by the end
      desc_bytes = {8'd7, REC_INTERFACE, 8'hFF, 8'h00, 8'h00, VIDEO_CLASS, VIDEO_CONTROL_SUB,
                    8'd6, REC_CLASS_SPECIFIC, SUB_INPUT_TERMINAL, 8'h00, 8'h01, 8'h02,
                    8'd8, REC_CLASS_SPECIFIC, SUB_PROCESSING_UNIT, 8'hFF};
      send_desc_bytes();
      hold_for_drain();
      // zero length stops the walk, nothing found
      desc_bytes = {8'h00, 8'hFF};
      send_desc_bytes();
      // one-byte record, short interface record, lone trailing length byte
      desc_bytes = {8'd1, 8'd3, REC_INTERFACE, 8'hAB, 8'd5};
      send_desc_bytes();
   endtask

   task automatic test_random_descriptors(int unsigned count);
      repeat (count) begin
         req_no_gaps = ($urandom_range(0, 4) == 0);
         send_random_descriptor();
         if ($urandom_range(0, 7) == 0) hold_for_drain();
      end
      req_no_gaps = 1'b0;
   endtask

   task automatic test_back_to_back(int unsigned count);
      req_no_gaps = 1'b1;
      rsp_no_stall <= 1'b1;
      repeat (count) send_random_descriptor();
      req_no_gaps = 1'b0;
      rsp_no_stall <= 1'b0;
   endtask

   task automatic test_noise_bytes(int unsigned count);
      for (int i = 0; i < count; i++)
         send_byte(rand_byte(), (i == count - 1) || ($urandom_range(0, 11) == 0));
   endtask

   initial begin
      start_new_descriptor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_descriptors();
      test_random_descriptors(20);
      test_back_to_back(6);
      test_noise_bytes(150);
      test_random_descriptors(4);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scan_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
